// ===== hdl/msched_pkg.sv =====
`timescale 1ns / 1ps
// shared types, sizes and codes of the multi-policy task scheduler
// no dependencies

package msched_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int TIME_BITS   = 16;
  localparam int PRIO_BITS   = 8;
  localparam int ARR_BITS    = 32;
  localparam int CTR_BITS    = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int IN_DATA_W   = 8 * ((ID_BITS + PRIO_BITS + 3 * TIME_BITS + ARR_BITS + 7) / 8);
  localparam int OUT_RAW_W   = 2 + 1 + ID_BITS + 3 + ID_BITS + CNT_W + 3 * CTR_BITS;
  localparam int OUT_DATA_W  = 8 * ((OUT_RAW_W + 7) / 8);

  typedef enum logic [2:0] {
    POL_FCFS = 3'd0,
    POL_RR   = 3'd1,
    POL_PRIO = 3'd2,
    POL_SJF  = 3'd3,
    POL_SRTF = 3'd4,
    POL_EDF  = 3'd5,
    POL_RSV6 = 3'd6,
    POL_RSV7 = 3'd7
  } policy_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_RSV  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_POLICY  = 2'd0,
    CFG_QUANTUM = 2'd1,
    CFG_TICK    = 2'd2,
    CFG_ENABLE  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    logic [TIME_BITS-1:0] burst;
    logic [TIME_BITS-1:0] rem;
    logic [TIME_BITS-1:0] dl;
    logic [ARR_BITS-1:0]  arr;
  } task_t;

endpackage

// ===== hdl/msched_better.sv =====
`timescale 1ns / 1ps
// shared selection unit: decides whether a scanned slot beats the current best
// depends on msched_pkg

module msched_better (
  input  msched_pkg::policy_e               policy_i,
  input  msched_pkg::task_t                 cand_i,
  input  logic [msched_pkg::CTR_BITS-1:0]   cand_order_i,
  input  logic [msched_pkg::CTR_BITS-1:0]   insert_cnt_i,
  input  msched_pkg::task_t                 best_i,
  input  logic [msched_pkg::CTR_BITS-1:0]   best_age_i,
  output logic [msched_pkg::CTR_BITS-1:0]   cand_age_o,
  output logic                              better_o
);
  import msched_pkg::*;

  logic                 older;
  logic                 arr_tie;
  logic [TIME_BITS-1:0] key_c;
  logic [TIME_BITS-1:0] key_b;

  assign cand_age_o = insert_cnt_i - cand_order_i;
  assign older      = cand_age_o > best_age_i;
  assign arr_tie    = cand_i.arr == best_i.arr;

  always_comb begin
    key_c = cand_i.burst;
    key_b = best_i.burst;
    case (policy_i)
      POL_SRTF: begin
        key_c = cand_i.rem;
        key_b = best_i.rem;
      end
      POL_EDF: begin
        key_c = cand_i.dl;
        key_b = best_i.dl;
      end
      default: begin
        key_c = cand_i.burst;
        key_b = best_i.burst;
      end
    endcase
  end

  always_comb begin
    case (policy_i)
      POL_PRIO: begin
        if (cand_i.prio != best_i.prio) better_o = cand_i.prio > best_i.prio;
        else if (!arr_tie)             better_o = cand_i.arr < best_i.arr;
        else                           better_o = older;
      end
      POL_SJF, POL_SRTF, POL_EDF: begin
        if (key_c != key_b)  better_o = key_c < key_b;
        else if (!arr_tie)   better_o = cand_i.arr < best_i.arr;
        else                 better_o = older;
      end
      default: better_o = older;
    endcase
  end

endmodule

// ===== hdl/multi_policy_task_scheduler.sv =====
`timescale 1ns / 1ps
// top level: ready table, running slot, counters and the item sequencer
// depends on msched_pkg and msched_better

// Usage:
//   Input stream s_axis: tuser carries req_type (0 add, 1 tick), tdata the task
//   fields. Output stream m_axis: one result transfer for every input transfer.
//   Configuration: cfg_we_i writes register cfg_idx_i (0 policy, 1 quantum_len,
//   2 tick_len, 3 run_enable) with cfg_data_i; write only while idle.
// Timing:
//   An add or an enabled tick walks all 16 table slots through one shared
//   compare unit, one slot per cycle, then passes through S_DECIDE, for a
//   tick also S_CREDIT, and S_OUT, which loads the output register. A tick
//   while run_enable is low goes from S_IDLE straight to S_OUT. The table
//   scan takes the largest share of the time of an item.
//   One item is in work at a time; s_axis_tready_o is high only when idle.
// Reset:
//   rst_ni clears slot valid bits, running slot, counters and registers to
//   their defaults; slot payload is written before it is ever read.
// Stalls:
//   A finished result waits in the output register while the next item is
//   accepted and worked on; that item stalls at its end until the register
//   frees up.

module multi_policy_task_scheduler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // task_id, task_priority, burst_len, remaining_len, deadline_time, arrival_time
  input  logic [msched_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // req_type
  input  logic                                 s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // add_status, running_valid, running_id, dispatched_flag, preempted_flag,
  // finished_flag, finished_id, ready_total, tick_total, preempt_total,
  // finish_total, zero fill
  output logic [msched_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_idx_i,
  input  logic [msched_pkg::TIME_BITS-1:0]     cfg_data_i
);
  import msched_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CREDIT,
    S_OUT
  } state_e;

  state_e state_q;

  // configuration
  policy_e              policy_q;
  logic [TIME_BITS-1:0] quantum_q;
  logic [TIME_BITS-1:0] tick_q;
  logic                 enable_q;

  // table
  logic                 valid_q [TABLE_DEPTH];
  task_t                slot_q  [TABLE_DEPTH];
  logic [CTR_BITS-1:0]  order_q [TABLE_DEPTH];
  logic [CNT_W-1:0]     ready_cnt_q;
  logic [CTR_BITS-1:0]  ins_cnt_q;

  // running slot
  logic                 run_valid_q;
  task_t                run_q;
  logic [CTR_BITS-1:0]  quant_q;

  logic [CTR_BITS-1:0]  tick_cnt_q;
  logic [CTR_BITS-1:0]  pre_cnt_q;
  logic [CTR_BITS-1:0]  fin_cnt_q;

  // item in work
  logic                 req_tick_q;
  task_t                req_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 dup_q;
  logic                 free_found_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic                 best_found_q;
  logic [IDX_W-1:0]     best_idx_q;
  task_t                best_q;
  logic [CTR_BITS-1:0]  best_age_q;
  status_e              status_q;
  logic                 disp_q;
  logic                 pre_q;
  logic                 fin_q;
  logic [ID_BITS-1:0]   fin_id_q;

  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // slot write port
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  task_t                wr_rec;

  logic                 better;
  logic [CTR_BITS-1:0]  cand_age;
  logic                 want_pre;
  logic [TIME_BITS-1:0] rem_next;
  logic [CTR_BITS:0]    quant_sum;
  logic [CTR_BITS-1:0]  quant_next;
  logic                 in_xfer;
  logic                 out_free;
  logic [OUT_RAW_W-1:0] out_raw;

  msched_better u_better (
    .policy_i     (policy_q),
    .cand_i       (slot_q[idx_q]),
    .cand_order_i (order_q[idx_q]),
    .insert_cnt_i (ins_cnt_q),
    .best_i       (best_q),
    .best_age_i   (best_age_q),
    .cand_age_o   (cand_age),
    .better_o     (better)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    case (policy_q)
      POL_RR:   want_pre = quant_q >= CTR_BITS'(quantum_q);
      POL_SRTF: want_pre = best_q.rem < run_q.rem;
      POL_EDF:  want_pre = best_q.dl < run_q.dl;
      default:  want_pre = 1'b0;
    endcase
  end

  assign rem_next   = (run_q.rem > tick_q) ? (run_q.rem - tick_q) : '0;
  assign quant_sum  = {1'b0, quant_q} + (CTR_BITS + 1)'(tick_q);
  assign quant_next = quant_sum[CTR_BITS] ? '1 : quant_sum[CTR_BITS-1:0];

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = free_idx_q;
    wr_rec = req_q;
    case (state_q)
      S_DECIDE: begin
        if (!req_tick_q) begin
          wr_en = !dup_q && !(run_valid_q && run_q.id == req_q.id) && free_found_q;
        end else if (run_valid_q && best_found_q && want_pre) begin
          wr_en  = 1'b1;
          wr_idx = best_idx_q;
          wr_rec = run_q;
        end
      end
      S_CREDIT: begin
        wr_rec     = run_q;
        wr_rec.rem = rem_next;
        wr_en      = run_valid_q && rem_next != '0 && policy_q == POL_RR
                     && quant_next >= CTR_BITS'(quantum_q) && free_found_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_idx]  <= wr_rec;
      order_q[wr_idx] <= ins_cnt_q;
    end
  end

  assign out_raw = {fin_cnt_q, pre_cnt_q, tick_cnt_q, ready_cnt_q, fin_id_q, fin_q, pre_q,
                    disp_q, (run_valid_q ? run_q.id : {ID_BITS{1'b0}}), run_valid_q,
                    status_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      policy_q     <= POL_FCFS;
      quantum_q    <= TIME_BITS'(100);
      tick_q       <= TIME_BITS'(10);
      enable_q     <= 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) valid_q[i] <= 1'b0;
      ready_cnt_q  <= '0;
      ins_cnt_q    <= '0;
      run_valid_q  <= 1'b0;
      run_q        <= '0;
      quant_q      <= '0;
      tick_cnt_q   <= '0;
      pre_cnt_q    <= '0;
      fin_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      req_tick_q   <= 1'b0;
      req_q        <= '0;
      idx_q        <= '0;
      dup_q        <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
      best_q       <= '0;
      best_age_q   <= '0;
      status_q     <= ST_OK;
      disp_q       <= 1'b0;
      pre_q        <= 1'b0;
      fin_q        <= 1'b0;
      fin_id_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_POLICY:  policy_q  <= policy_e'(cfg_data_i[2:0]);
          CFG_QUANTUM: quantum_q <= cfg_data_i;
          CFG_TICK:    tick_q    <= cfg_data_i;
          CFG_ENABLE:  enable_q  <= cfg_data_i[0];
          default:     ;
        endcase
      end

      // in S_OUT the output register is reloaded below instead
      if (out_valid_q && m_axis_tready_i && state_q != S_OUT) out_valid_q <= 1'b0;

      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
        ins_cnt_q       <= ins_cnt_q + 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            req_tick_q   <= s_axis_tuser_i;
            req_q.id     <= s_axis_tdata_i[ID_BITS-1:0];
            req_q.prio   <= s_axis_tdata_i[ID_BITS +: PRIO_BITS];
            req_q.burst  <= s_axis_tdata_i[ID_BITS + PRIO_BITS +: TIME_BITS];
            req_q.rem    <= s_axis_tdata_i[ID_BITS + PRIO_BITS + TIME_BITS +: TIME_BITS];
            req_q.dl     <= s_axis_tdata_i[ID_BITS + PRIO_BITS + 2*TIME_BITS +: TIME_BITS];
            req_q.arr    <= s_axis_tdata_i[ID_BITS + PRIO_BITS + 3*TIME_BITS +: ARR_BITS];
            idx_q        <= '0;
            dup_q        <= 1'b0;
            free_found_q <= 1'b0;
            best_found_q <= 1'b0;
            status_q     <= ST_OK;
            disp_q       <= 1'b0;
            pre_q        <= 1'b0;
            fin_q        <= 1'b0;
            fin_id_q     <= '0;
            if (s_axis_tuser_i && !enable_q) begin
              state_q <= S_OUT;
            end else begin
              if (s_axis_tuser_i) tick_cnt_q <= tick_cnt_q + 1'b1;
              state_q <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // one slot per cycle through the shared compare unit
          if (valid_q[idx_q]) begin
            if (slot_q[idx_q].id == req_q.id) dup_q <= 1'b1;
            if (!best_found_q || better) begin
              best_found_q <= 1'b1;
              best_idx_q   <= idx_q;
              best_q       <= slot_q[idx_q];
              best_age_q   <= cand_age;
            end
          end else if (!free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= idx_q;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == IDX_W'(TABLE_DEPTH - 1)) state_q <= S_DECIDE;
        end

        S_DECIDE: begin
          if (!req_tick_q) begin
            if (dup_q || (run_valid_q && run_q.id == req_q.id)) status_q <= ST_DUP;
            else if (!free_found_q)                             status_q <= ST_FULL;
            else                                                ready_cnt_q <= ready_cnt_q + 1'b1;
            state_q <= S_OUT;
          end else begin
            if (run_valid_q && best_found_q && want_pre) begin
              // swap running task with best ready task
              run_q     <= best_q;
              quant_q   <= '0;
              pre_q     <= 1'b1;
              disp_q    <= 1'b1;
              pre_cnt_q <= pre_cnt_q + 1'b1;
            end else if (!run_valid_q && best_found_q) begin
              valid_q[best_idx_q] <= 1'b0;
              ready_cnt_q         <= ready_cnt_q - 1'b1;
              run_q               <= best_q;
              run_valid_q         <= 1'b1;
              quant_q             <= '0;
              disp_q              <= 1'b1;
              if (!free_found_q || best_idx_q < free_idx_q) begin
                free_found_q <= 1'b1;
                free_idx_q   <= best_idx_q;
              end
            end
            state_q <= S_CREDIT;
          end
        end

        S_CREDIT: begin
          if (run_valid_q) begin
            run_q.rem <= rem_next;
            quant_q   <= quant_next;
            if (rem_next == '0) begin
              fin_q       <= 1'b1;
              fin_id_q    <= run_q.id;
              run_valid_q <= 1'b0;
              fin_cnt_q   <= fin_cnt_q + 1'b1;
            end else if (wr_en) begin
              // quantum used up: requeue into lowest free slot
              run_valid_q <= 1'b0;
              ready_cnt_q <= ready_cnt_q + 1'b1;
              pre_q       <= 1'b1;
              pre_cnt_q   <= pre_cnt_q + 1'b1;
            end
          end
          state_q <= S_OUT;
        end

        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= OUT_DATA_W'(out_raw);
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/multi_policy_task_scheduler_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the multi-policy task scheduler: directed adds and
// ticks, then random traffic under every policy, checked against a behavioral predictor
// depends on msched_pkg and multi_policy_task_scheduler

module multi_policy_task_scheduler_tb;
  import msched_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 48;

  typedef struct {
    logic [1:0]  status;
    logic        run_vld;
    logic [7:0]  run_id;
    logic        disp;
    logic        pre;
    logic        fin;
    logic [7:0]  fin_id;
    logic [4:0]  ready;
    logic [31:0] ticks;
    logic [31:0] preempts;
    logic [31:0] finishes;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [TIME_BITS-1:0] cfg_data = '0;

  always #10 clk_i = ~clk_i;

  multi_policy_task_scheduler DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // scheduler mirror
  logic        slot_vld [TABLE_DEPTH];
  task_t       slot_task [TABLE_DEPTH];
  logic [31:0] slot_ord [TABLE_DEPTH];
  logic [31:0] ins_ctr;
  logic        cur_vld;
  task_t       cur_task;
  logic [31:0] cur_qused;
  logic [31:0] tick_ctr, pre_ctr, fin_ctr;
  policy_e     cur_policy;
  logic [15:0] cur_quantum, cur_tick;
  logic        cur_enable;

  sched_result_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 0;
  int long_hold_req = 0;
  int long_hold_seen = 0;
  int rx_hold = 0;

  function automatic bit slot_better(int a, int b);
    logic [15:0] ka, kb;
    if (cur_policy >= POL_PRIO && cur_policy <= POL_EDF) begin
      if (cur_policy == POL_PRIO) begin
        if (slot_task[a].prio != slot_task[b].prio) return slot_task[a].prio > slot_task[b].prio;
      end else begin
        case (cur_policy)
          POL_SJF: begin ka = slot_task[a].burst; kb = slot_task[b].burst; end
          POL_SRTF: begin ka = slot_task[a].rem; kb = slot_task[b].rem; end
          default: begin ka = slot_task[a].dl; kb = slot_task[b].dl; end
        endcase
        if (ka != kb) return ka < kb;
      end
      if (slot_task[a].arr != slot_task[b].arr) return slot_task[a].arr < slot_task[b].arr;
    end
    return (ins_ctr - slot_ord[a]) > (ins_ctr - slot_ord[b]);
  endfunction

  function automatic int best_slot();
    int best = -1;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (slot_vld[i] && (best < 0 || slot_better(i, best))) best = i;
    return best;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (!slot_vld[i]) return i;
    return -1;
  endfunction

  function automatic void store_task(int i, task_t t);
    slot_task[i] = t;
    slot_ord[i] = ins_ctr;
    ins_ctr++;
    slot_vld[i] = 1'b1;
  endfunction

  function automatic void reset_mirror();
    for (int i = 0; i < TABLE_DEPTH; i++) slot_vld[i] = 1'b0;
    ins_ctr = '0; cur_vld = 1'b0; cur_task = '0; cur_qused = '0;
    tick_ctr = '0; pre_ctr = '0; fin_ctr = '0;
    cur_policy = POL_FCFS; cur_quantum = 16'd100; cur_tick = 16'd10; cur_enable = 1'b0;
  endfunction

  function automatic sched_result_t schedule_item(bit is_tick, task_t t);
    sched_result_t r;
    int c, f;
    bit dup, swap;
    task_t nxt;
    r = '{default: '0};
    if (!is_tick) begin
      dup = cur_vld && cur_task.id == t.id;
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (slot_vld[i] && slot_task[i].id == t.id) dup = 1'b1;
      if (dup) r.status = ST_DUP;
      else begin
        f = free_slot();
        if (f < 0) r.status = ST_FULL;
        else store_task(f, t);
      end
    end else if (cur_enable) begin
      tick_ctr++;
      if (cur_vld) begin
        c = best_slot();
        if (c >= 0) begin
          case (cur_policy)
            POL_RR: swap = cur_qused >= 32'(cur_quantum);
            POL_SRTF: swap = slot_task[c].rem < cur_task.rem;
            POL_EDF: swap = slot_task[c].dl < cur_task.dl;
            default: swap = 1'b0;
          endcase
          if (swap) begin
            nxt = slot_task[c];
            store_task(c, cur_task);
            cur_task = nxt;
            cur_qused = '0;
            r.pre = 1'b1; r.disp = 1'b1;
            pre_ctr++;
          end
        end
      end
      if (!cur_vld) begin
        c = best_slot();
        if (c >= 0) begin
          cur_task = slot_task[c];
          slot_vld[c] = 1'b0;
          cur_vld = 1'b1;
          cur_qused = '0;
          r.disp = 1'b1;
        end
      end
      if (cur_vld) begin
        cur_task.rem = cur_task.rem > cur_tick ? cur_task.rem - cur_tick : '0;
        cur_qused = (cur_qused > 32'hFFFF_FFFF - 32'(cur_tick)) ? 32'hFFFF_FFFF
                                                                : cur_qused + 32'(cur_tick);
        if (cur_task.rem == '0) begin
          r.fin = 1'b1; r.fin_id = cur_task.id;
          cur_vld = 1'b0;
          fin_ctr++;
        end else if (cur_policy == POL_RR && cur_qused >= 32'(cur_quantum)) begin
          f = free_slot();
          if (f >= 0) begin
            store_task(f, cur_task);
            cur_vld = 1'b0;
            r.pre = 1'b1;
            pre_ctr++;
          end
        end
      end
    end
    r.run_vld = cur_vld;
    r.run_id = cur_vld ? cur_task.id : '0;
    r.ready = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) r.ready += 5'(slot_vld[i]);
    r.ticks = tick_ctr; r.preempts = pre_ctr; r.finishes = fin_ctr;
    return r;
  endfunction

  // result side: stall draw, long hold-off and comparison
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    sched_result_t e;
    int d;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_policy_task_scheduler test failed");
      $finish;
    end else if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("add_status", 32'(e.status), 32'(m_tdata[1:0]));
          check_field("running_valid", 32'(e.run_vld), 32'(m_tdata[2]));
          check_field("running_id", 32'(e.run_id), 32'(m_tdata[10:3]));
          check_field("dispatched_flag", 32'(e.disp), 32'(m_tdata[11]));
          check_field("preempted_flag", 32'(e.pre), 32'(m_tdata[12]));
          check_field("finished_flag", 32'(e.fin), 32'(m_tdata[13]));
          check_field("finished_id", 32'(e.fin_id), 32'(m_tdata[21:14]));
          check_field("ready_total", 32'(e.ready), 32'(m_tdata[26:22]));
          check_field("tick_total", e.ticks, m_tdata[58:27]);
          check_field("preempt_total", e.preempts, m_tdata[90:59]);
          check_field("finish_total", e.finishes, m_tdata[122:91]);
        end
      end
      if (long_hold_req != long_hold_seen) begin
        long_hold_seen <= long_hold_req;
        rx_hold <= 400;
        m_tready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_tready <= (rx_hold == 1);
      end else if (m_tvalid && m_tready) begin
        d = no_idle ? 0 : $urandom_range(0, 15);
        rx_hold <= d;
        m_tready <= (d == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // sender side
  task automatic send_item(bit is_tick, task_t t);
    int gap;
    bit taken;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= is_tick;
    s_tdata <= {t.arr, t.dl, t.rem, t.burst, t.prio, t.id};
    do begin
      @(negedge clk_i);
      taken = s_tready;
      @(posedge clk_i);
    end while (!taken);
    expected_q.push_back(schedule_item(is_tick, t));
  endtask

  task automatic go_idle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POLICY: cur_policy = policy_e'(val[2:0]);
      CFG_QUANTUM: cur_quantum = val;
      CFG_TICK: cur_tick = val;
      CFG_ENABLE: cur_enable = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_mode(policy_e pol, logic [15:0] quantum, logic [15:0] tick_len,
                          bit enable);
    write_reg(CFG_POLICY, 16'(pol));
    write_reg(CFG_QUANTUM, quantum);
    write_reg(CFG_TICK, tick_len);
    write_reg(CFG_ENABLE, 16'(enable));
  endtask

  function automatic task_t make_task(logic [7:0] id);
    task_t t;
    int    m;
    t.id = id;
    t.prio = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    t.burst = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
    t.dl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
    t.arr = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 5));
    m = $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0) t.rem = 16'($urandom);
    else t.rem = (32'(cur_tick) * 32'(m) > 32'd65535) ? 16'hFFFF
                 : 16'(32'(cur_tick) * 32'(m) + $urandom_range(0, 3));
    return t;
  endfunction

  task automatic test_directed_table();
    task_t t;
    // ticks ignored while disabled, id and field extremes, duplicates
    send_item(1, '0);
    send_item(0, '0);
    send_item(0, '1);
    send_item(0, '0);
    go_idle();
    write_reg(CFG_ENABLE, 16'd1);
    send_item(1, '0);  // dispatches the zero-length task, finishes at once
    send_item(1, '0);  // long task starts running
    t = '1;
    send_item(0, t);   // id of the running task
    for (int i = 1; i <= TABLE_DEPTH + 1; i++) begin
      t = make_task(8'(i));
      send_item(0, t);  // last one finds the table full
    end
    go_idle();
  endtask

  task automatic run_random(policy_e pol, logic [15:0] quantum, logic [15:0] tick_len,
                            bit enable, int n_items, bit quiet, bit hold);
    task_t t;
    set_mode(pol, quantum, tick_len, enable);
    no_idle = quiet;
    for (int i = 0; i < n_items; i++) begin
      if (hold && i == 5) long_hold_req++;
      if ($urandom_range(0, 9) < 4) begin
        t = make_task($urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(0, 23)));
        send_item(0, t);
      end else begin
        t = {$urandom, $urandom, $urandom};
        send_item(1, t);
      end
    end
    go_idle();
    no_idle = 0;
  endtask

  task automatic test_fcfs_and_spare();
    run_random(POL_FCFS, 100, 65535, 1, 50, 0, 0);
    run_random(POL_RSV6, 1, 40, 1, 45, 0, 0);
    run_random(POL_RSV7, 65535, 5, 1, 45, 0, 0);
    run_random(POL_FCFS, 100, 1, 0, 20, 0, 0);
  endtask

  task automatic test_round_robin();
    run_random(POL_RR, 1, 1, 1, 50, 0, 0);
    run_random(POL_RR, 65535, 65535, 1, 45, 1, 0);
    run_random(POL_RR, 30, 10, 1, 60, 0, 1);
  endtask

  task automatic test_keyed_policies();
    run_random(POL_PRIO, 50, 20, 1, 55, 0, 0);
    run_random(POL_SJF, 50, 30, 1, 55, 0, 0);
    run_random(POL_SRTF, 50, 15, 1, 60, 0, 1);
    run_random(POL_EDF, 50, 25, 1, 60, 1, 0);
  endtask

  initial begin
    reset_mirror();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_table();
    test_round_robin();
    test_keyed_policies();
    test_fcfs_and_spare();
    if (errors == 0) begin
      $display("multi_policy_task_scheduler test passed");
    end else begin
      $display("multi_policy_task_scheduler test failed");
    end
    $finish;
  end

endmodule
